### rtl/hrs_pkg.sv
// Shared widths, operation codes and fixed-point constants for the receiver selector.
package hrs_pkg;

    localparam int unsigned MAX_RECEIVERS_DEF = 16;

    localparam int unsigned COUNT_W = 5;
    localparam int unsigned ENTRY_W = 4;
    localparam int unsigned VEC_W   = 16;
    localparam int unsigned FRAC_W  = 16;

    localparam int unsigned MUL_W  = VEC_W + 1;
    localparam int unsigned PROD_W = 2 * MUL_W;
    localparam int unsigned ACC_W  = 34;

    localparam int unsigned RAD_W  = 32;
    localparam int unsigned REM_W  = 18;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_TRACK = 1'b1;

    localparam logic signed [ACC_W-1:0] Q_ONE = ACC_W'(64'sd268435456);
    localparam logic signed [ACC_W-1:0] Q_SAT = ACC_W'(64'sd536870912);

endpackage

### rtl/hrs_in_if.sv
// Input channel: load and track words with valid/ready handshake.
interface hrs_in_if
    import hrs_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic                     operation;
    logic [ENTRY_W-1:0]       entry_index;
    logic signed [VEC_W-1:0]  reflect_x;
    logic signed [VEC_W-1:0]  reflect_y;
    logic signed [VEC_W-1:0]  reflect_z;
    logic [FRAC_W-1:0]        attenuation_in;
    logic signed [VEC_W-1:0]  sun_x;
    logic signed [VEC_W-1:0]  sun_y;
    logic signed [VEC_W-1:0]  sun_z;

    modport source (
        output valid, operation, entry_index, reflect_x, reflect_y, reflect_z,
               attenuation_in, sun_x, sun_y, sun_z,
        input  ready
    );

    modport sink (
        input  valid, operation, entry_index, reflect_x, reflect_y, reflect_z,
               attenuation_in, sun_x, sun_y, sun_z,
        output ready
    );
endinterface

### rtl/hrs_out_if.sv
// Output channel: selected receiver word with valid/ready handshake.
interface hrs_out_if
    import hrs_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               found;
    logic [ENTRY_W-1:0] best_index;
    logic [FRAC_W-1:0]  incidence_cos;
    logic [FRAC_W-1:0]  attenuation_out;
    logic [FRAC_W-1:0]  efficiency;

    modport source (
        output valid, found, best_index, incidence_cos, attenuation_out, efficiency,
        input  ready
    );

    modport sink (
        input  valid, found, best_index, incidence_cos, attenuation_out, efficiency,
        output ready
    );
endinterface

### rtl/heliostat_receiver_select.sv
// Receiver selector: table, shared multiplier, bit-serial square root, best-score search.
// Load word: accepted while idle, table entry written at the accept edge.
// Track word over n entries: each entry passes read, dot product, clamp, square root, score
// and compare, with the square root skipped when the clamp saturates.
// The result is registered as S_PUT returns to S_IDLE, after any output stall clears.
// Reset clears control state and receiver_count; the table holds no reset and needs no clearing.
module heliostat_receiver_select
    import hrs_pkg::*;
#(
    parameter int unsigned MAX_RECEIVERS = MAX_RECEIVERS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    hrs_in_if.sink             i_in,
    hrs_out_if.source          o_out,
    input  logic               i_cfg_we,
    input  logic [COUNT_W-1:0] i_cfg_data
);

    localparam int unsigned IDX_W = (MAX_RECEIVERS > 1) ? $clog2(MAX_RECEIVERS) : 1;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_READ  = 4'd1;
    localparam logic [3:0] S_MUL   = 4'd2;
    localparam logic [3:0] S_CLAMP = 4'd3;
    localparam logic [3:0] S_SQRT  = 4'd4;
    localparam logic [3:0] S_EFF   = 4'd5;
    localparam logic [3:0] S_CMP   = 4'd6;
    localparam logic [3:0] S_PUT   = 4'd7;

    logic [3*VEC_W-1:0] mem_vec [MAX_RECEIVERS];
    logic [FRAC_W-1:0]  mem_att [MAX_RECEIVERS];

    logic [3*VEC_W-1:0] r_rd_vec;
    logic [FRAC_W-1:0]  r_rd_att;

    logic [3:0]              r_state, n_state;
    logic [IDX_W-1:0]        r_idx, n_idx;
    logic [IDX_W-1:0]        r_last, n_last;
    logic [1:0]              r_step, n_step;
    logic [3:0]              r_bits, n_bits;
    logic signed [ACC_W-1:0] r_acc, n_acc;
    logic signed [PROD_W-1:0] r_prod, n_prod;
    logic signed [VEC_W-1:0] r_sun_x, n_sun_x;
    logic signed [VEC_W-1:0] r_sun_y, n_sun_y;
    logic signed [VEC_W-1:0] r_sun_z, n_sun_z;
    logic [RAD_W-1:0]        r_rad, n_rad;
    logic [REM_W-1:0]        r_rem, n_rem;
    logic [FRAC_W-1:0]       r_root, n_root;
    logic                    r_have, n_have;
    logic [IDX_W-1:0]        r_best_idx, n_best_idx;
    logic [FRAC_W-1:0]       r_best_cos, n_best_cos;
    logic [FRAC_W-1:0]       r_best_att, n_best_att;
    logic [FRAC_W-1:0]       r_best_eff, n_best_eff;
    logic [COUNT_W-1:0]      r_count, n_count;
    logic                    r_out_valid, n_out_valid;
    logic                    r_out_found, n_out_found;
    logic [ENTRY_W-1:0]      r_out_idx, n_out_idx;
    logic [FRAC_W-1:0]       r_out_cos, n_out_cos;
    logic [FRAC_W-1:0]       r_out_att, n_out_att;
    logic [FRAC_W-1:0]       r_out_eff, n_out_eff;

    logic                    in_acc;
    logic                    load_wr;
    logic [IDX_W-1:0]        wr_addr;
    logic [31:0]             cnt_lim;
    logic signed [MUL_W-1:0] mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [ACC_W-1:0] q_val;
    logic [REM_W+1:0]        sq_sh, sq_trial;
    logic [FRAC_W-1:0]       cur_eff;

    assign i_in.ready = (r_state == S_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;
    assign load_wr    = in_acc && (i_in.operation == OP_LOAD)
                        && (32'(i_in.entry_index) < 32'(MAX_RECEIVERS));
    assign wr_addr    = IDX_W'(i_in.entry_index);
    assign cnt_lim    = (32'(r_count) > 32'(MAX_RECEIVERS)) ? 32'(MAX_RECEIVERS)
                                                             : 32'(r_count);

    always_ff @(posedge i_clk) begin
        if (load_wr) begin
            mem_vec[wr_addr] <= {i_in.reflect_z, i_in.reflect_y, i_in.reflect_x};
            mem_att[wr_addr] <= i_in.attenuation_in;
        end
        r_rd_vec <= mem_vec[r_idx];
        r_rd_att <= mem_att[r_idx];
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (r_state == S_EFF) begin
            mul_a = $signed({1'b0, r_root});
            mul_b = $signed({1'b0, r_rd_att});
        end else begin
            case (r_step)
                2'd0: begin
                    mul_a = MUL_W'(r_sun_x);
                    mul_b = MUL_W'($signed(r_rd_vec[VEC_W-1:0]));
                end
                2'd1: begin
                    mul_a = MUL_W'(r_sun_y);
                    mul_b = MUL_W'($signed(r_rd_vec[2*VEC_W-1:VEC_W]));
                end
                2'd2: begin
                    mul_a = MUL_W'(r_sun_z);
                    mul_b = MUL_W'($signed(r_rd_vec[3*VEC_W-1:2*VEC_W]));
                end
                default: begin
                    mul_a = '0;
                    mul_b = '0;
                end
            endcase
        end
    end

    assign mul_p    = mul_a * mul_b;
    assign q_val    = r_acc + Q_ONE;
    assign sq_sh    = {r_rem, r_rad[RAD_W-1:RAD_W-2]};
    assign sq_trial = {2'b00, r_root, 2'b01};
    assign cur_eff  = r_prod[2*FRAC_W-1:FRAC_W];

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_last      = r_last;
        n_step      = r_step;
        n_bits      = r_bits;
        n_acc       = r_acc;
        n_prod      = mul_p;
        n_sun_x     = r_sun_x;
        n_sun_y     = r_sun_y;
        n_sun_z     = r_sun_z;
        n_rad       = r_rad;
        n_rem       = r_rem;
        n_root      = r_root;
        n_have      = r_have;
        n_best_idx  = r_best_idx;
        n_best_cos  = r_best_cos;
        n_best_att  = r_best_att;
        n_best_eff  = r_best_eff;
        n_count     = i_cfg_we ? i_cfg_data : r_count;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_found = r_out_found;
        n_out_idx   = r_out_idx;
        n_out_cos   = r_out_cos;
        n_out_att   = r_out_att;
        n_out_eff   = r_out_eff;

        case (r_state)
            S_IDLE: begin
                if (in_acc && i_in.operation == OP_TRACK) begin
                    n_sun_x    = i_in.sun_x;
                    n_sun_y    = i_in.sun_y;
                    n_sun_z    = i_in.sun_z;
                    n_idx      = '0;
                    n_last     = IDX_W'(cnt_lim - 32'd1);
                    n_step     = '0;
                    n_have     = 1'b0;
                    n_best_idx = '0;
                    n_best_cos = '0;
                    n_best_att = '0;
                    n_best_eff = '0;
                    n_state    = (cnt_lim == 32'd0) ? S_PUT : S_READ;
                end
            end
            S_READ: begin
                n_step  = '0;
                n_state = S_MUL;
            end
            S_MUL: begin
                if (r_step == 2'd0) begin
                    n_acc = '0;
                end else begin
                    n_acc = r_acc + ACC_W'(r_prod);
                end
                if (r_step == 2'd3) begin
                    n_step  = '0;
                    n_state = S_CLAMP;
                end else begin
                    n_step = r_step + 2'd1;
                end
            end
            S_CLAMP: begin
                n_rem  = '0;
                n_root = '0;
                n_bits = '0;
                if (q_val[ACC_W-1]) begin
                    n_rad   = '0;
                    n_state = S_SQRT;
                end else if (q_val >= Q_SAT) begin
                    n_root  = '1;
                    n_state = S_EFF;
                end else begin
                    n_rad   = {q_val[28:0], 3'b000};
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                if (sq_sh >= sq_trial) begin
                    n_rem  = REM_W'(sq_sh - sq_trial);
                    n_root = {r_root[FRAC_W-2:0], 1'b1};
                end else begin
                    n_rem  = sq_sh[REM_W-1:0];
                    n_root = {r_root[FRAC_W-2:0], 1'b0};
                end
                n_rad  = {r_rad[RAD_W-3:0], 2'b00};
                n_bits = r_bits + 4'd1;
                if (r_bits == 4'd15) begin
                    n_state = S_EFF;
                end
            end
            S_EFF: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (!r_have || cur_eff > r_best_eff) begin
                    n_have     = 1'b1;
                    n_best_idx = r_idx;
                    n_best_cos = r_root;
                    n_best_att = r_rd_att;
                    n_best_eff = cur_eff;
                end
                if (r_idx == r_last) begin
                    n_state = S_PUT;
                end else begin
                    n_idx   = r_idx + IDX_W'(1);
                    n_state = S_READ;
                end
            end
            S_PUT: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_found = r_have;
                    n_out_idx   = ENTRY_W'(r_best_idx);
                    n_out_cos   = r_best_cos;
                    n_out_att   = r_best_att;
                    n_out_eff   = r_best_eff;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
            r_step      <= '0;
            r_bits      <= '0;
            r_have      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_idx       <= n_idx;
            r_step      <= n_step;
            r_bits      <= n_bits;
            r_have      <= n_have;
        end
    end

    always_ff @(posedge i_clk) begin
        r_last     <= n_last;
        r_acc      <= n_acc;
        r_prod     <= n_prod;
        r_sun_x    <= n_sun_x;
        r_sun_y    <= n_sun_y;
        r_sun_z    <= n_sun_z;
        r_rad      <= n_rad;
        r_rem      <= n_rem;
        r_root     <= n_root;
        r_best_idx <= n_best_idx;
        r_best_cos <= n_best_cos;
        r_best_att <= n_best_att;
        r_best_eff <= n_best_eff;
        r_out_found <= n_out_found;
        r_out_idx  <= n_out_idx;
        r_out_cos  <= n_out_cos;
        r_out_att  <= n_out_att;
        r_out_eff  <= n_out_eff;
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.found           = r_out_found;
    assign o_out.best_index      = r_out_idx;
    assign o_out.incidence_cos   = r_out_cos;
    assign o_out.attenuation_out = r_out_att;
    assign o_out.efficiency      = r_out_eff;

    a_track_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.operation == OP_TRACK) |=> !i_in.ready)
        else $error("input ready while a track word is in progress");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.found) |->
            (o_out.best_index == '0 && o_out.incidence_cos == '0
             && o_out.attenuation_out == '0 && o_out.efficiency == '0))
        else $error("empty search returned nonzero fields");

    a_eff_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.found) |->
            (o_out.efficiency == FRAC_W'((32'(o_out.incidence_cos)
                                          * 32'(o_out.attenuation_out)) >> FRAC_W)))
        else $error("efficiency does not match cosine times attenuation");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> (r_idx <= r_last))
        else $error("search index ran past the last entry");

endmodule
